FILE: sv/base64_stream_codec_macros.svh
// assertion macros shared by the base64 stream codec rtl
// no dependencies; users must have clk_i and rst_ni in scope
`ifndef BASE64_STREAM_CODEC_MACROS_SVH
`define BASE64_STREAM_CODEC_MACROS_SVH

// condition that holds on every clock edge out of reset
`define B64SC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// condition that implies another one on the next clock edge
`define B64SC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: sv/b64sc_pkg.sv
// types, constants and alphabet functions for the base64 stream codec
// no dependencies; imported by b64sc_step and base64_stream_codec
package b64sc_pkg;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);
  localparam int unsigned IdxW   = $clog2(MaxRes);
  localparam int unsigned AddrW  = 3;

  localparam logic [7:0] CharPad = 8'h3D;  // '='

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam logic [AddrW-1:0] RegMode = 3'd0;

  typedef struct packed {
    logic [1:0]  enc_phase;
    logic [5:0]  enc_carry;
    logic [11:0] dec_acc;
    logic [2:0]  dec_bit_count;
  } state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       last;
  } res_t;

  typedef res_t [MaxRes-1:0] res_vec_t;

  // 6-bit group to character of the standard alphabet
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};         // 'A'..'Z'
    end else if (v < 6'd52) begin
      c = 8'd71 + {2'b00, v};         // 'a'..'z'
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;          // '0'..'9'
    end else if (v == 6'd62) begin
      c = 8'd43;                      // '+'
    end else begin
      c = 8'd47;                      // '/'
    end
    return c;
  endfunction

  // character to {in alphabet, 6-bit value}
  function automatic logic [6:0] dec_value(input logic [7:0] c);
    logic [7:0] v;
    logic       ok;
    ok = 1'b1;
    v  = 8'd0;
    if (c >= 8'd65 && c <= 8'd90) begin
      v = c - 8'd65;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      v = c - 8'd71;
    end else if (c >= 8'd48 && c <= 8'd57) begin
      v = c + 8'd4;
    end else if (c == 8'd43) begin
      v = 8'd62;
    end else if (c == 8'd47) begin
      v = 8'd63;
    end else begin
      ok = 1'b0;
    end
    return {ok, v[5:0]};
  endfunction

endpackage

FILE: sv/b64sc_step.sv
// combinational step: one element in, up to four results and the next state out
// depends on b64sc_pkg
module b64sc_step (
  input  logic                 mode_i,
  input  logic [7:0]           data_i,
  input  logic                 last_i,
  input  b64sc_pkg::state_t    st_i,
  output b64sc_pkg::state_t    st_o,
  output b64sc_pkg::res_vec_t  res_o,
  output logic [b64sc_pkg::CntW-1:0] cnt_o
);
  import b64sc_pkg::*;

  logic [1:0]  ph;
  logic [6:0]  dv;
  logic [11:0] acc_new;
  logic [3:0]  bits;

  always_comb begin
    st_o    = st_i;
    res_o   = '0;
    cnt_o   = '0;
    ph      = (st_i.enc_phase == 2'd3) ? 2'd0 : st_i.enc_phase;
    dv      = dec_value(data_i);
    acc_new = {st_i.dec_acc[5:0], dv[5:0]};
    bits    = {1'b0, st_i.dec_bit_count} + 4'd6;

    if (mode_i == ModeEncode) begin
      case (ph)
        2'd0: begin
          res_o[0]       = '{enc_char(data_i[7:2]), 1'b1, 1'b0};
          st_o.enc_carry = {4'b0000, data_i[1:0]};
          st_o.enc_phase = 2'd1;
          cnt_o          = CntW'(1);
          if (last_i) begin
            res_o[1] = '{enc_char({data_i[1:0], 4'b0000}), 1'b1, 1'b0};
            res_o[2] = '{CharPad, 1'b1, 1'b0};
            res_o[3] = '{CharPad, 1'b1, 1'b1};
            cnt_o    = CntW'(4);
          end
        end
        2'd1: begin
          res_o[0]       = '{enc_char({st_i.enc_carry[1:0], data_i[7:4]}), 1'b1, 1'b0};
          st_o.enc_carry = {2'b00, data_i[3:0]};
          st_o.enc_phase = 2'd2;
          cnt_o          = CntW'(1);
          if (last_i) begin
            res_o[1] = '{enc_char({data_i[3:0], 2'b00}), 1'b1, 1'b0};
            res_o[2] = '{CharPad, 1'b1, 1'b1};
            cnt_o    = CntW'(3);
          end
        end
        default: begin
          res_o[0]       = '{enc_char({st_i.enc_carry[3:0], data_i[7:6]}), 1'b1, 1'b0};
          res_o[1]       = '{enc_char(data_i[5:0]), 1'b1, last_i};
          st_o.enc_carry = '0;
          st_o.enc_phase = 2'd0;
          cnt_o          = CntW'(2);
        end
      endcase
      if (last_i) begin
        st_o.enc_phase = '0;
        st_o.enc_carry = '0;
      end
    end else begin
      if (dv[6]) begin
        if (bits >= 4'd8) begin
          bits     = bits - 4'd8;
          res_o[0] = '{8'(acc_new >> bits[2:0]), 1'b1, last_i};
          cnt_o    = CntW'(1);
        end
        st_o.dec_acc       = acc_new;
        st_o.dec_bit_count = bits[2:0];
      end
      if (last_i) begin
        // end marker when the last element yields no byte
        if (cnt_o == '0) begin
          res_o[0] = '{8'h00, 1'b0, 1'b1};
          cnt_o    = CntW'(1);
        end
        st_o.dec_acc       = '0;
        st_o.dec_bit_count = '0;
      end
    end
  end

endmodule

FILE: sv/base64_stream_codec.sv
// top level of the streaming base64 codec: apb mode register, input stage, result buffer
// depends on b64sc_pkg, b64sc_step and base64_stream_codec_macros.svh
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-------------------------------
//   input    | in        | in_valid_i / in_ready_o    | data_in_i, last_in_i
//   output   | out       | out_valid_o / out_ready_i  | data_out_o, data_valid_o, last_out_o
//   config   | in        | psel/penable/pwrite/pready | paddr, pwdata, prdata (mode)
//
// one request enters the input register per cycle while in_ready_o is high; it is then
// expanded into zero to four results held in a four-slot result buffer
// results leave one per cycle while out_ready_i is high; the first result is offered
// once the request has moved from the input register into the result buffer
// the result buffer port is the limit: a request moves on only when the buffer is empty
// or its last pending result is taken; meanwhile the input register holds one request
// and then stalls
// reset clears the input valid, the buffer count, the codec state and mode (encode)
`include "base64_stream_codec_macros.svh"

module base64_stream_codec (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_in_i,
  input  logic        last_in_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_out_o,
  output logic        data_valid_o,
  output logic        last_out_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [b64sc_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import b64sc_pkg::*;

  // mode register
  logic mode_q, mode_d;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[AddrW-1] == RegMode[AddrW-1]);   // word index 0
  assign prdata  = reg_sel ? {31'b0, mode_q} : 32'b0;

  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      mode_d = pwdata[0];
    end
  end

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_data_q;
  logic       in_last_q;

  // result buffer
  res_vec_t          res_q;
  logic [CntW-1:0]   rem_q, rem_d;
  logic [IdxW-1:0]   idx_q, idx_d;

  // codec state
  state_t st_q, st_d;

  // step outputs
  state_t            st_nxt;
  res_vec_t          res_nxt;
  logic [CntW-1:0]   cnt_nxt;

  logic take;   // output request accepted
  logic move;   // input register advances into the result buffer

  b64sc_step u_step (
    .mode_i (mode_q),
    .data_i (in_data_q),
    .last_i (in_last_q),
    .st_i   (st_q),
    .st_o   (st_nxt),
    .res_o  (res_nxt),
    .cnt_o  (cnt_nxt)
  );

  assign out_valid_o  = (rem_q != '0);
  assign data_out_o   = res_q[idx_q].data;
  assign data_valid_o = res_q[idx_q].dvalid;
  assign last_out_o   = res_q[idx_q].last;

  assign take = out_valid_o && out_ready_i;
  // buffer free now, or its final result leaves this cycle
  assign move = in_vld_q && ((rem_q == '0) || ((rem_q == CntW'(1)) && out_ready_i));

  assign in_ready_o = !in_vld_q || move;

  always_comb begin
    in_vld_d = in_vld_q;
    rem_d    = rem_q;
    idx_d    = idx_q;
    st_d     = st_q;
    if (move) begin
      rem_d = cnt_nxt;
      idx_d = '0;
      st_d  = st_nxt;
    end else if (take) begin
      rem_d = rem_q - CntW'(1);
      idx_d = idx_q + IdxW'(1);
    end
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (move) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeEncode;
      in_vld_q <= 1'b0;
      rem_q    <= '0;
      idx_q    <= '0;
      st_q     <= '0;
    end else begin
      mode_q   <= mode_d;
      in_vld_q <= in_vld_d;
      rem_q    <= rem_d;
      idx_q    <= idx_d;
      st_q     <= st_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= data_in_i;
      in_last_q <= last_in_i;
    end
    if (move) begin
      res_q <= res_nxt;
    end
  end

  // checks
  `B64SC_ASSERT(a_rem_range, rem_q <= CntW'(MaxRes), "result count over buffer depth")
  `B64SC_ASSERT(a_slot_range, ({1'b0, idx_q} + rem_q) <= (CntW+1)'(MaxRes), "result index past buffer end")
  `B64SC_ASSERT(a_last_final, !(out_valid_o && last_out_o) || (rem_q == CntW'(1)), "last flag before final slot")
  `B64SC_ASSERT_NEXT(a_drain, take && !move && (rem_q == CntW'(1)), !out_valid_o, "buffer not empty after final take")

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for base64_stream_codec: encode and decode streams over valid/ready
// predicts every result in-bench and checks it field by field; needs b64sc_pkg and the rtl
`timescale 1ns / 100ps

module testbench;
  import b64sc_pkg::*;

  // run length and pacing
  localparam int CycleLimit  = 500000;  // well above the slowest correct run
  localparam int DrainCycles = 8;       // covers a skipped character still in flight
  localparam int RandomItems = 396;     // random requests after the directed part
  localparam int PhaseItems  = 44;      // requests per mode setting in the random part

  // dut signals
  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_in_i;
  logic        last_in_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  data_out_o;
  logic        data_valid_o;
  logic        last_out_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state: mode register and both codec halves, all zero out of reset
  logic        codec_mode = ModeEncode;
  logic [1:0]  enc_slot   = '0;   // bytes of the current 3-byte group seen
  logic [5:0]  enc_rest   = '0;   // low bits of the last byte not yet emitted
  logic [11:0] dec_bits   = '0;   // decode window, only the low dec_fill bits matter
  logic [2:0]  dec_fill   = '0;   // pending bit count in dec_bits

  res_t pending_results[$];       // results still owed by the dut, oldest first
  int   fail_count  = 0;
  int   cycle_count = 0;
  logic steady      = 1'b0;       // when set neither side inserts gaps

  string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  base64_stream_codec uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_in_i    (data_in_i),
    .last_in_i    (last_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .data_out_o   (data_out_o),
    .data_valid_o (data_valid_o),
    .last_out_o   (last_out_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    return b64_alphabet[v];
  endfunction

  // alphabet position of a character, -1 when it is not in the alphabet
  function automatic int char_value(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (b64_alphabet[i] == c) begin
        return i;
      end
    end
    return -1;
  endfunction

  task automatic owe_result(input logic [7:0] d, input logic dv, input logic l);
    res_t r;
    r.data   = d;
    r.dvalid = dv;
    r.last   = l;
    pending_results.insert(pending_results.size(), r);
  endtask

  // works out the results of one accepted request and queues them
  task automatic expand_request(input logic [7:0] d, input logic l);
    int          v;
    int          fill;
    logic [11:0] window;
    logic        produced;
    if (codec_mode == ModeEncode) begin
      case (enc_slot)
        2'd1: begin
          owe_result(b64_char({enc_rest[1:0], d[7:4]}), 1'b1, 1'b0);
          enc_rest = {2'b00, d[3:0]};
          enc_slot = 2'd2;
          // two bytes in: flush the last four bits and one pad
          if (l) begin
            owe_result(b64_char({enc_rest[3:0], 2'b00}), 1'b1, 1'b0);
            owe_result(CharPad, 1'b1, 1'b1);
          end
        end
        2'd2: begin
          // group complete, the final character carries the last flag
          owe_result(b64_char({enc_rest[3:0], d[7:6]}), 1'b1, 1'b0);
          owe_result(b64_char(d[5:0]), 1'b1, l);
          enc_rest = '0;
          enc_slot = 2'd0;
        end
        default: begin
          // slot 0, and the unreachable slot 3 taken as 0
          owe_result(b64_char(d[7:2]), 1'b1, 1'b0);
          enc_rest = {4'b0000, d[1:0]};
          enc_slot = 2'd1;
          if (l) begin
            owe_result(b64_char({enc_rest[1:0], 4'b0000}), 1'b1, 1'b0);
            owe_result(CharPad, 1'b1, 1'b0);
            owe_result(CharPad, 1'b1, 1'b1);
          end
        end
      endcase
      if (l) begin
        enc_slot = '0;
        enc_rest = '0;
      end
    end else begin
      v        = char_value(d);
      produced = 1'b0;
      // characters outside the alphabet leave the window untouched
      if (v >= 0) begin
        fill     = int'(dec_fill) + 6;
        dec_bits = {dec_bits[5:0], v[5:0]};
        if (fill >= 8) begin
          fill   = fill - 8;
          window = dec_bits >> fill;
          owe_result(window[7:0], 1'b1, l);
          produced = 1'b1;
        end
        dec_fill = fill[2:0];
      end
      if (l) begin
        // a last request that gives no byte still closes the message
        if (!produced) begin
          owe_result(8'h00, 1'b0, 1'b1);
        end
        dec_bits = '0;
        dec_fill = '0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: sample at the rising edge, before the nonblocking updates land
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : watch_ports
    res_t want;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr == RegMode) begin
        codec_mode = pwdata[0];
      end
      if (in_valid_i && in_ready_o) begin
        expand_request(data_in_i, last_in_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result data %h dvalid %b last %b", $time,
                   data_out_o, data_valid_o, last_out_o);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (want.data !== data_out_o) begin
            $display("%0t: data_out expected %h actual %h", $time, want.data, data_out_o);
            fail_count++;
          end
          if (want.dvalid !== data_valid_o) begin
            $display("%0t: data_valid expected %b actual %b", $time, want.dvalid,
                     data_valid_o);
            fail_count++;
          end
          if (want.last !== last_out_o) begin
            $display("%0t: last_out expected %b actual %b", $time, want.last, last_out_o);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // pacing: most gaps short, a few long
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 6);
    end
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk_i) begin : pace_results
    int stall_left;
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  = stall_left - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  = pick_gap() - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // shared driver tasks, each entered just after a rising edge
  // ---------------------------------------------------------------------------

  // one request; valid stays up into the next request when no gap is drawn
  task automatic send_item(input logic [7:0] d, input logic l);
    int gap;
    in_valid_i <= 1'b1;
    data_in_i  <= d;
    last_in_i  <= l;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    if (!steady && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending and wait for every owed result, then let a skipped request drain
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // apb write of the mode register with junk in the upper bits, then read back
  task automatic write_mode(input logic m);
    logic [31:0] word;
    logic [31:0] seen;
    word    = $urandom();
    word[0] = m;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegMode;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    seen = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (seen !== {31'd0, codec_mode}) begin
      $display("%0t: mode readback expected %h actual %h", $time, {31'd0, codec_mode}, seen);
      fail_count++;
    end
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // one, two and four byte messages: double pad, single pad, full group and wrap
  task automatic test_encode_padding();
    write_mode(ModeEncode);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hFB, 1'b0);
    send_item(8'hEF, 1'b0);
    send_item(8'hBE, 1'b0);
    send_item(8'h80, 1'b1);
    settle();
  endtask

  // alphabet edges, skipped characters, end marker on a skipped last request
  // and on a last request with too few bits, last flag riding on a byte
  task automatic test_decode_skip_and_marker();
    write_mode(ModeDecode);
    send_item("/", 1'b0);
    send_item(8'h00, 1'b0);
    send_item("+", 1'b0);
    send_item("9", 1'b0);
    send_item("0", 1'b0);
    send_item(CharPad, 1'b0);
    send_item("z", 1'b0);
    send_item(8'hFF, 1'b1);
    send_item("a", 1'b0);
    send_item("Z", 1'b0);
    send_item("A", 1'b1);
    send_item(" ", 1'b1);
    send_item("Q", 1'b1);
    settle();
  endtask

  // open messages in both modes, each resumes after the other mode ran
  task automatic test_mode_switch_resume();
    write_mode(ModeEncode);
    send_item(8'h12, 1'b0);
    settle();
    write_mode(ModeDecode);
    send_item("Q", 1'b0);
    settle();
    write_mode(ModeEncode);
    send_item(8'h34, 1'b1);
    settle();
    write_mode(ModeDecode);
    send_item("Q", 1'b0);
    send_item("Q", 1'b1);
    settle();
  endtask

  function automatic logic [7:0] random_raw_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly alphabet characters, some padding, whitespace and arbitrary bytes
  function automatic logic [7:0] random_text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return b64_char(6'($urandom_range(0, 63)));
    end else if (r < 90) begin
      return CharPad;
    end else if (r < 94) begin
      case ($urandom_range(0, 3))
        0:       return 8'h20;
        1:       return 8'h0A;
        2:       return 8'h0D;
        default: return 8'h09;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // phases of random messages, mode redrawn between phases
  task automatic test_random_messages();
    int   sent;
    int   phase;
    int   phase_end;
    int   len;
    logic m;
    logic close_msg;
    logic paused;
    sent   = 0;
    phase  = 0;
    paused = 1'b0;
    while (sent < RandomItems) begin
      settle();
      if (phase == 0) begin
        m = ModeEncode;
      end else if (phase == 1) begin
        m = ModeDecode;
      end else begin
        m = 1'($urandom_range(0, 1));
      end
      write_mode(m);
      steady    = (phase % 4 == 3);
      phase_end = sent + PhaseItems;
      while (sent < phase_end) begin
        if (m == ModeEncode) begin
          len = $urandom_range(1, 9);
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 30) : $urandom_range(1, 12);
        end
        // keep the phase to its request budget
        if (len > phase_end - sent) begin
          len = phase_end - sent;
        end
        // now and then a message is left open and carries into a later phase
        close_msg = ($urandom_range(0, 9) != 0);
        for (int k = 0; k < len; k++) begin
          if (m == ModeEncode) begin
            send_item(random_raw_byte(), close_msg && k == len - 1);
          end else begin
            send_item(random_text_char(), close_msg && k == len - 1);
          end
          sent++;
        end
        // hold the sender once mid-phase until the dut has caught up
        if (phase == 1 && !paused && sent > phase_end - PhaseItems / 2) begin
          settle();
          paused = 1'b1;
        end
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    data_in_i  = '0;
    last_in_i  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_encode_padding();
    test_decode_skip_and_marker();
    test_mode_switch_resume();
    test_random_messages();
    settle();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/b64sc_pkg.sv
sv/b64sc_step.sv
sv/base64_stream_codec.sv
tb/sv/testbench.sv
